>>> hw/rtl/sclg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sclg_pkg;

  // Generator constants: multiplier, offset and modulus of each generator.
  localparam logic [10:0] GA_MUL = 11'd1156;
  localparam logic [20:0] GA_OFF = 21'd312342;
  localparam logic [20:0] GA_MOD = 21'd1334025;
  localparam logic [10:0] GB_MUL = 11'd1366;
  localparam logic [20:0] GB_OFF = 21'd827291;
  localparam logic [20:0] GB_MOD = 21'd1519572;
  localparam logic [10:0] GC_MUL = 11'd1156;
  localparam logic [20:0] GC_OFF = 21'd198273;
  localparam logic [20:0] GC_MOD = 21'd1329657;

  // Generator states after reset.
  localparam logic [20:0] GA_RESET = 21'd872978;
  localparam logic [20:0] GB_RESET = 21'd518652;
  localparam logic [20:0] GC_RESET = 21'd226543;

  // Default depth of the shuffle table.
  localparam int TABLE_DEPTH_DEFAULT = 97;

  // Quotient bits the divider works through for generator and result jobs.
  localparam logic [4:0] STEPS_LCG  = 5'd11;
  localparam logic [4:0] STEPS_FULL = 5'd31;

  // Request kinds carried in tuser.
  localparam logic OP_SEED = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_START,
    ST_WAIT,
    ST_READ,
    ST_CAPT,
    ST_WRITE,
    ST_OUT
  } state_t;

  // Arithmetic jobs handed to the shared divider.
  typedef enum logic [2:0] {
    JOB_SEED_A,
    JOB_SEED_B,
    JOB_SEED_C,
    JOB_STEP_A,
    JOB_SLOT,
    JOB_STEP_B,
    JOB_STEP_C,
    JOB_RESULT
  } job_t;

  // Divider control and status.
  typedef struct packed {
    logic       start;
    logic [4:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/sclg_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sclg_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 97
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sclg_div.sv
`timescale 1ns / 1ps
`default_nettype none

module sclg_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sclg_pkg::div_ctl_t ctl,
  input  wire logic [31:0]       dividend,
  input  wire logic [30:0]       divisor,
  output sclg_pkg::div_sts_t     sts,
  output logic      [30:0]       rem,
  output logic      [30:0]       quot
);

  import sclg_pkg::*;

  logic [30:0] dvs;
  logic [31:0] low;
  logic [4:0]  count;
  logic        busy;
  logic        done;
  logic [31:0] trial;
  logic [31:0] diff;
  logic        fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial = {rem, low[31]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  assign sts.busy = busy;
  assign sts.done = done;

  // The caller guarantees that the quotient fits in the requested number of
  // bits, so the bits above them already lie below the divisor.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        dvs   <= divisor;
        rem   <= 31'(dividend >> ctl.steps);
        low   <= dividend << (6'd32 - {1'b0, ctl.steps});
        quot  <= '0;
        count <= ctl.steps;
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= fits ? diff[30:0] : trial[30:0];
        low   <= low << 1;
        quot  <= {quot[29:0], fits};
        count <= count - 5'd1;
        if (count == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/shuffled_combined_lcg_generator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Contents
// s_*       in         s_tvalid/s_tready  tuser: op; tdata: seed_value, modulus
// m_*       out        m_tvalid/m_tready  tdata: random_value
//
// Every modulo, the slot pick and the result reduction go through one shared
// shift-subtract divider taking one quotient bit a cycle; a generator job works
// through 11 quotient bits. No request is taken while a draw or a reseed is in
// progress.
// Reset is synchronous; the table reads as zero through per-slot valid bits,
// so no clearing pass is needed. A stalled result waits in the output register.

module shuffled_combined_lcg_generator_unit #(
  parameter int TABLE_DEPTH = sclg_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // seed_value[30:0], modulus[61:31], zero
  input  wire logic        s_tuser,   // op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata    // random_value[30:0], zero
);

  import sclg_pkg::*;

  localparam int         IW         = $clog2(TABLE_DEPTH);
  localparam logic [4:0] SLOT_STEPS = 5'($clog2(TABLE_DEPTH));

  state_t           state;
  state_t           state_next;
  job_t             job;
  job_t             job_next;

  logic             op;
  logic [30:0]      seed;
  logic [30:0]      modulus;
  logic [20:0]      gen_a;
  logic [20:0]      gen_b;
  logic [20:0]      gen_c;
  logic [31:0]      operand;
  logic [30:0]      divisor;
  logic [4:0]       steps;
  logic [IW-1:0]    slot;
  logic [IW-1:0]    idx;
  logic [30:0]      entry;
  logic [30:0]      result;
  logic [TABLE_DEPTH-1:0] valid;
  logic             out_valid;
  logic [31:0]      out_data;

  logic             accept;
  logic             out_free;
  logic [20:0]      mul_s;
  logic [10:0]      mul_k;
  logic [31:0]      prod;
  logic [31:0]      load_val;
  logic [30:0]      load_dvs;
  logic [4:0]       load_steps;
  logic [30:0]      fresh_x;

  div_ctl_t         div_ctl;
  div_sts_t         div_sts;
  logic [30:0]      div_rem;
  logic [30:0]      div_quot;

  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic             ram_re;
  logic [30:0]      ram_rdata;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Fresh table value: generator B high, generator C low, kept to 31 bits.
  assign fresh_x = {gen_b[17:0], 13'd0} ^ {13'd0, gen_c[20:3]};

  // Shared multiplier and the divider operands for the current job.
  assign prod = 32'(mul_s) * 32'(mul_k);

  always_comb begin
    mul_s      = gen_a;
    mul_k      = GA_MUL;
    load_val   = prod;
    load_dvs   = 31'(GA_MOD);
    load_steps = STEPS_LCG;
    unique case (job)
      JOB_SEED_A: begin
        load_val = 32'(gen_a) + 32'(seed);
      end
      JOB_SEED_B: begin
        load_val = 32'(gen_b) + 32'(seed);
        load_dvs = 31'(GB_MOD);
      end
      JOB_SEED_C: begin
        load_val = 32'(gen_c) + 32'(seed);
        load_dvs = 31'(GC_MOD);
      end
      JOB_STEP_A: begin
        load_val = prod + 32'(GA_OFF);
      end
      JOB_SLOT: begin
        mul_k      = 11'(TABLE_DEPTH);
        load_steps = SLOT_STEPS;
      end
      JOB_STEP_B: begin
        mul_s    = gen_b;
        mul_k    = GB_MUL;
        load_val = prod + 32'(GB_OFF);
        load_dvs = 31'(GB_MOD);
      end
      JOB_STEP_C: begin
        mul_s    = gen_c;
        mul_k    = GC_MUL;
        load_val = prod + 32'(GC_OFF);
        load_dvs = 31'(GC_MOD);
      end
      JOB_RESULT: begin
        load_val   = 32'(entry);
        load_dvs   = modulus;
        load_steps = STEPS_FULL;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      job   <= JOB_SEED_A;
    end else begin
      state <= state_next;
      job   <= job_next;
    end
  end

  // Next state, next job and strobes.
  always_comb begin
    state_next    = state;
    job_next      = job;
    div_ctl.start = (state == ST_START);
    div_ctl.steps = steps;
    ram_we        = (state == ST_WRITE);
    ram_re        = (state == ST_READ);
    ram_waddr     = (op == OP_DRAW) ? slot : idx;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOAD;
          job_next   = (s_tuser == OP_DRAW) ? JOB_STEP_A : JOB_SEED_A;
        end
      end
      ST_LOAD: begin
        state_next = ST_START;
      end
      ST_START: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_sts.done) begin
          unique case (job)
            JOB_SEED_A: begin
              job_next   = JOB_SEED_B;
              state_next = ST_LOAD;
            end
            JOB_SEED_B: begin
              job_next   = JOB_SEED_C;
              state_next = ST_LOAD;
            end
            JOB_SEED_C: begin
              job_next   = JOB_STEP_B;
              state_next = ST_LOAD;
            end
            JOB_STEP_A: begin
              job_next   = JOB_SLOT;
              state_next = ST_LOAD;
            end
            JOB_SLOT: begin
              state_next = ST_READ;
            end
            JOB_STEP_B: begin
              job_next   = JOB_STEP_C;
              state_next = ST_LOAD;
            end
            JOB_STEP_C: begin
              state_next = ST_WRITE;
            end
            JOB_RESULT: begin
              state_next = ST_OUT;
            end
          endcase
        end
      end
      ST_READ: begin
        state_next = ST_CAPT;
      end
      ST_CAPT: begin
        job_next   = JOB_STEP_B;
        state_next = ST_LOAD;
      end
      ST_WRITE: begin
        if (op == OP_DRAW) begin
          if (modulus != 31'd0) begin
            job_next   = JOB_RESULT;
            state_next = ST_LOAD;
          end else begin
            state_next = ST_OUT;
          end
        end else if (idx == '0) begin
          state_next = ST_IDLE;
        end else begin
          job_next   = JOB_STEP_B;
          state_next = ST_LOAD;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // Request capture and divider operand registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= s_tuser;
      seed    <= s_tdata[30:0];
      modulus <= s_tdata[61:31];
    end
    if (state == ST_LOAD) begin
      operand <= load_val;
      divisor <= load_dvs;
      steps   <= load_steps;
    end
  end

  // Generator states and the valid bit of each table slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_a <= GA_RESET;
      gen_b <= GB_RESET;
      gen_c <= GC_RESET;
      valid <= '0;
    end else begin
      if (state == ST_WAIT && div_sts.done) begin
        unique case (job)
          JOB_SEED_A, JOB_STEP_A: gen_a <= div_rem[20:0];
          JOB_SEED_B, JOB_STEP_B: gen_b <= div_rem[20:0];
          JOB_SEED_C, JOB_STEP_C: gen_c <= div_rem[20:0];
          JOB_SLOT, JOB_RESULT: begin
          end
        endcase
      end
      if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
      end
    end
  end

  // Slot, fill index, drawn entry and result.
  always_ff @(posedge clk) begin
    if (state == ST_WAIT && div_sts.done) begin
      if (job == JOB_SLOT) begin
        slot <= (div_quot >= 31'(TABLE_DEPTH)) ? '0 : div_quot[IW-1:0];
      end
      if (job == JOB_SEED_C) begin
        idx <= IW'(TABLE_DEPTH - 1);
      end
      if (job == JOB_RESULT) begin
        result <= div_rem;
      end
    end
    if (state == ST_CAPT) begin
      entry <= valid[slot] ? ram_rdata : 31'd0;
    end
    if (state == ST_WRITE) begin
      if (op == OP_DRAW) begin
        result <= entry;
      end else if (idx != '0) begin
        idx <= idx - IW'(1);
      end
    end
  end

  // Output register: holds a result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (state == ST_OUT && out_free) begin
      out_data <= {1'b0, result};
    end
  end

  sclg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (operand),
    .divisor  (divisor),
    .sts      (div_sts),
    .rem      (div_rem),
    .quot     (div_quot)
  );

  sclg_ram #(
    .WIDTH (31),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (fresh_x),
    .re    (ram_re),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // The divider is only started when it has finished the previous job.
  a_div_start_idle : assert property (@(posedge clk) disable iff (rst)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider started while busy");

  // The slot read from the table always lies inside the table.
  a_slot_range : assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (32'(slot) < 32'(TABLE_DEPTH)))
    else $error("slot index beyond table depth");

  // Every generator state stays below its modulus.
  a_gen_range : assert property (@(posedge clk) disable iff (rst)
    (gen_a < GA_MOD) && (gen_b < GB_MOD) && (gen_c < GC_MOD))
    else $error("generator state out of range");

endmodule

`default_nettype wire
